### design/fhp_pkg.sv
// shared types and constants for the hexagonal lattice-gas SIR cell update
// no dependencies; imported by every module of the block
package fhp_pkg;

  localparam int DIRS      = 6;
  localparam int SLOT_W    = 2;
  localparam int SLOTS_W   = DIRS * SLOT_W;
  localparam int RAND_W    = 48;
  localparam int THR_W     = 9;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_SUSC  = 2'd1,
    SLOT_INF   = 2'd2,
    SLOT_REC   = 2'd3
  } slot_e;

  localparam logic [CFG_IDX_W-1:0] CFG_INFECT_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_THR = 2'd1;

  localparam logic [THR_W-1:0] INFECT_THR_RST  = 9'd154;
  localparam logic [THR_W-1:0] RECOVER_THR_RST = 9'd52;

  // occupancy patterns of the collision rules, bit d set for a full slot d
  localparam logic [DIRS-1:0] OCC_HEAD_0_5    = 6'h21;
  localparam logic [DIRS-1:0] OCC_HEAD_1_4    = 6'h12;
  localparam logic [DIRS-1:0] OCC_HEAD_2_3    = 6'h0C;
  localparam logic [DIRS-1:0] OCC_TRIPLE_034  = 6'h19;
  localparam logic [DIRS-1:0] OCC_TRIPLE_125  = 6'h26;

  typedef struct packed {
    logic [SLOTS_W-1:0] incoming_slots;
    logic [SLOTS_W-1:0] current_slots;
    logic [RAND_W-1:0]  infect_random;
    logic [RAND_W-1:0]  recover_random;
  } in_t;

  typedef struct packed {
    logic [SLOTS_W-1:0] next_slots;
    logic               changed;
    logic [CNT_W-1:0]   susceptible_count;
    logic [CNT_W-1:0]   infected_count;
    logic [CNT_W-1:0]   recovered_count;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0] infect_thr;
    logic [THR_W-1:0] recover_thr;
  } cfg_t;

endpackage

### design/fhp_sir_cell_update.sv
// top level of the hexagonal lattice-gas SIR cell update
// depends on fhp_pkg, fhp_collide, fhp_lane and fhp_merge
//
// usage:
//   in_valid_i/in_ready_o carry one cell transaction (incoming slots, current
//   slots, two sets of six random lanes). out_valid_o/out_ready_i carry the
//   result transaction: new slots, changed flag and S/I/R counts.
//   cfg_we_i writes a threshold register (index 0 infection, 1 recovery)
//   with no wait; other indexes are ignored. write only while idle.
//   accept loads the first stage register, then the output register. one
//   transaction per cycle while out_ready_i stays high: collision and
//   the six lanes fill the first stage, the merge of counts the second.
//   a stalled receiver holds the output register; the first stage still
//   takes one more transaction, after which in_ready_o drops until the
//   output drains.
//   reset empties both stages and loads thresholds 154 and 52.
module fhp_sir_cell_update import fhp_pkg::*; #(
  parameter int RANDOM_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THR_W-1:0]     cfg_data_i
);

  localparam int PAD_W = DIRS * RANDOM_BITS;

  cfg_t               cfg_q;
  logic               s1_valid_q;
  logic [SLOTS_W-1:0] s1_slots_q;
  logic [SLOTS_W-1:0] s1_cur_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               s2_ready;
  logic               in_fire;
  logic [SLOTS_W-1:0] coll_slots;
  logic               any_inf;
  logic [SLOTS_W-1:0] lane_slots_d;
  logic [PAD_W-1:0]   inf_pad;
  logic [PAD_W-1:0]   rec_pad;
  out_t               merge_res;

  // lanes past the 48 input bits read as zero
  assign inf_pad = PAD_W'(in_data_i.infect_random);
  assign rec_pad = PAD_W'(in_data_i.recover_random);

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.infect_thr  <= INFECT_THR_RST;
      cfg_q.recover_thr <= RECOVER_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INFECT_THR:  cfg_q.infect_thr  <= cfg_data_i;
        CFG_RECOVER_THR: cfg_q.recover_thr <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fhp_collide u_collide (
    .slots_i   (in_data_i.incoming_slots),
    .slots_o   (coll_slots),
    .any_inf_o (any_inf)
  );

  for (genvar d = 0; d < DIRS; d++) begin : g_lane
    slot_e lane_out;
    fhp_lane #(.RB(RANDOM_BITS)) u_lane (
      .slot_i     (slot_e'(coll_slots[d*SLOT_W +: SLOT_W])),
      .any_inf_i  (any_inf),
      .inf_lane_i (inf_pad[d*RANDOM_BITS +: RANDOM_BITS]),
      .rec_lane_i (rec_pad[d*RANDOM_BITS +: RANDOM_BITS]),
      .cfg_i      (cfg_q),
      .slot_o     (lane_out)
    );
    assign lane_slots_d[d*SLOT_W +: SLOT_W] = lane_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_slots_q <= lane_slots_d;
      s1_cur_q   <= in_data_i.current_slots;
    end
  end

  fhp_merge u_merge (
    .slots_i   (s1_slots_q),
    .current_i (s1_cur_q),
    .res_o     (merge_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_q <= merge_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_q.susceptible_count} + {1'b0, out_q.infected_count}
                     + {1'b0, out_q.recovered_count}) <= 4'(DIRS))
    else $error("slot counts exceed the number of directions");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_slots_q) && $stable(s1_cur_q))
    else $error("first stage lost or changed a stalled transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("output register changed while stalled");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with both stages full");
`endif

endmodule

### design/fhp_collide.sv
// deterministic two- and three-particle collision of one cell
// depends on fhp_pkg for slot codes and occupancy patterns
module fhp_collide import fhp_pkg::*; (
  input  logic [SLOTS_W-1:0] slots_i,
  output logic [SLOTS_W-1:0] slots_o,
  output logic               any_inf_o
);

  slot_e           s_in  [DIRS];
  slot_e           s_out [DIRS];
  logic [DIRS-1:0] occ;

  always_comb begin
    for (int d = 0; d < DIRS; d++) begin
      s_in[d] = slot_e'(slots_i[d*SLOT_W +: SLOT_W]);
      occ[d]  = (s_in[d] != SLOT_EMPTY);
      s_out[d] = s_in[d];
    end
    // particles keep their code while redirected
    case (occ)
      OCC_HEAD_0_5: begin
        s_out[0] = SLOT_EMPTY; s_out[5] = SLOT_EMPTY;
        s_out[1] = s_in[0];    s_out[4] = s_in[5];
      end
      OCC_HEAD_1_4: begin
        s_out[1] = SLOT_EMPTY; s_out[4] = SLOT_EMPTY;
        s_out[3] = s_in[1];    s_out[2] = s_in[4];
      end
      OCC_HEAD_2_3: begin
        s_out[2] = SLOT_EMPTY; s_out[3] = SLOT_EMPTY;
        s_out[0] = s_in[2];    s_out[5] = s_in[3];
      end
      OCC_TRIPLE_034: begin
        s_out[0] = SLOT_EMPTY; s_out[3] = SLOT_EMPTY; s_out[4] = SLOT_EMPTY;
        s_out[1] = s_in[0];    s_out[5] = s_in[3];    s_out[2] = s_in[4];
      end
      OCC_TRIPLE_125: begin
        s_out[1] = SLOT_EMPTY; s_out[2] = SLOT_EMPTY; s_out[5] = SLOT_EMPTY;
        s_out[3] = s_in[1];    s_out[0] = s_in[2];    s_out[4] = s_in[5];
      end
      default: begin
      end
    endcase
    any_inf_o = 1'b0;
    for (int d = 0; d < DIRS; d++) begin
      slots_o[d*SLOT_W +: SLOT_W] = s_out[d];
      if (s_out[d] == SLOT_INF) any_inf_o = 1'b1;
    end
  end

endmodule

### design/fhp_lane.sv
// one direction lane: infection then recovery test of a single slot
// depends on fhp_pkg for slot codes and the threshold struct
module fhp_lane import fhp_pkg::*; #(
  parameter int RB = 8
) (
  input  slot_e         slot_i,
  input  logic          any_inf_i,
  input  logic [RB-1:0] inf_lane_i,
  input  logic [RB-1:0] rec_lane_i,
  input  cfg_t          cfg_i,
  output slot_e         slot_o
);

  localparam int CMP_W = (RB > THR_W) ? RB : THR_W;

  logic  inf_hit;
  logic  rec_hit;
  slot_e mid;

  assign inf_hit = CMP_W'(inf_lane_i) < CMP_W'(cfg_i.infect_thr);
  assign rec_hit = CMP_W'(rec_lane_i) < CMP_W'(cfg_i.recover_thr);

  always_comb begin
    mid = slot_i;
    if (any_inf_i && slot_i == SLOT_SUSC && inf_hit) mid = SLOT_INF;
    // a slot infected just now may recover in the same update
    slot_o = mid;
    if (mid == SLOT_INF && rec_hit) slot_o = SLOT_REC;
  end

endmodule

### design/fhp_merge.sv
// merges the lane results: population counts and change flag
// depends on fhp_pkg for the result struct and slot codes
module fhp_merge import fhp_pkg::*; (
  input  logic [SLOTS_W-1:0] slots_i,
  input  logic [SLOTS_W-1:0] current_i,
  output out_t               res_o
);

  slot_e s;

  always_comb begin
    res_o.next_slots        = slots_i;
    res_o.changed           = (slots_i != current_i);
    res_o.susceptible_count = '0;
    res_o.infected_count    = '0;
    res_o.recovered_count   = '0;
    for (int d = 0; d < DIRS; d++) begin
      s = slot_e'(slots_i[d*SLOT_W +: SLOT_W]);
      case (s)
        SLOT_SUSC: res_o.susceptible_count = res_o.susceptible_count + 3'd1;
        SLOT_INF:  res_o.infected_count    = res_o.infected_count + 3'd1;
        SLOT_REC:  res_o.recovered_count   = res_o.recovered_count + 3'd1;
        default: begin
        end
      endcase
    end
  end

endmodule
